/* design/tangent_grid_inverse_index_core_defines.svh */
// assertion macros for the tangent grid inverse index core
// expects aclk and aresetn in the scope of each use
`ifndef TANGENT_GRID_INVERSE_INDEX_CORE_DEFINES_SVH
`define TANGENT_GRID_INVERSE_INDEX_CORE_DEFINES_SVH

`define TGII_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define TGII_ASSERT_AFTER_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error(msg);

`endif

/* design/tgii_pkg.sv */
// shared constants, types and the arctangent table of the grid index core
// no dependencies
package tgii_pkg;

    localparam int INDEX_BITS    = 16;
    localparam int CORDIC_STAGES = 24;

    localparam int COORD_W   = 32;
    localparam int CW        = 35;
    localparam int ZW        = 32;
    localparam int GRID_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 64;
    localparam int RND_SHIFT = 45;
    localparam int RND_W     = PROD_W + 1 - RND_SHIFT;

    localparam logic [PROD_W:0]   RND_HALF = (PROD_W + 1)'(1) << (RND_SHIFT - 1);
    localparam logic [PROD_W-1:0] MAX_IDX  = (PROD_W'(1) << INDEX_BITS) - PROD_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SCALE = 3'd5;

    localparam logic [COORD_W-1:0] RST_RANGE_LOW   = 32'd0;
    localparam logic [COORD_W-1:0] RST_RANGE_HIGH  = 32'd65536;
    localparam logic [COORD_W-1:0] RST_CENTRE      = 32'd32768;
    localparam logic [COORD_W-1:0] RST_WIDTH       = 32'd65536;
    localparam logic [COORD_W-1:0] RST_ANGLE_START = 32'd0;
    localparam logic [COORD_W-1:0] RST_INDEX_SCALE = 32'd65536;

    typedef struct packed {
        logic [COORD_W-1:0] range_low;
        logic [COORD_W-1:0] range_high;
        logic [COORD_W-1:0] centre;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] angle_start;
        logic [COORD_W-1:0] index_scale;
    } tgii_cfg_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [ZW-1:0] z;
        logic          oor;
    } cordic_word_t;

    // atan(2^-i) in Q3.29
    function automatic logic [ZW-1:0] atan_entry(input int idx);
        case (idx)
            0:  return 32'd421657428;
            1:  return 32'd248918915;
            2:  return 32'd131521918;
            3:  return 32'd66762579;
            4:  return 32'd33510843;
            5:  return 32'd16771758;
            6:  return 32'd8387925;
            7:  return 32'd4194219;
            8:  return 32'd2097141;
            9:  return 32'd1048575;
            10: return 32'd524288;
            11: return 32'd262144;
            12: return 32'd131072;
            13: return 32'd65536;
            14: return 32'd32768;
            15: return 32'd16384;
            16: return 32'd8192;
            17: return 32'd4096;
            18: return 32'd2048;
            19: return 32'd1024;
            20: return 32'd512;
            21: return 32'd256;
            22: return 32'd128;
            23: return 32'd64;
            24: return 32'd32;
            25: return 32'd16;
            26: return 32'd8;
            27: return 32'd4;
            28: return 32'd2;
            29: return 32'd1;
            default: return '0;
        endcase
    endfunction

endpackage

/* design/tangent_grid_inverse_index_core.sv */
// path from input word to result word: front register, cordic pipeline, diff, product and output registers
// throughput: one word per cycle while the output does not stall, set by the fully unrolled cordic pipeline
// each stage has its own valid and ready, so empty stages fill while the output waits
// reset (synchronous, active low) clears all valid bits and loads register defaults
// top level: config registers, front stage, cordic pipeline, scaling back end
module tangent_grid_inverse_index_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [tgii_pkg::COORD_W-1:0] s_coord_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tgii_pkg::GRID_W-1:0]    m_grid_index,
    output logic                           m_out_of_range,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tgii_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tgii_pkg::COORD_W-1:0]   cfg_wdata
);
    import tgii_pkg::*;

    `include "tangent_grid_inverse_index_core_defines.svh"

    tgii_cfg_t    cfg;
    logic         f_valid;
    logic         f_ready;
    cordic_word_t f_word;
    logic         c_valid;
    logic         c_ready;
    cordic_word_t c_word;

    tgii_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tgii_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .coord     (s_coord_value),
        .cfg       (cfg),
        .out_valid (f_valid),
        .out_word  (f_word),
        .out_ready (f_ready)
    );

    tgii_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_word   (f_word),
        .out_valid (c_valid),
        .out_word  (c_word),
        .out_ready (c_ready)
    );

    tgii_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (c_valid),
        .in_ready       (c_ready),
        .in_word        (c_word),
        .cfg            (cfg),
        .out_valid      (m_valid),
        .out_grid_index (m_grid_index),
        .out_oor        (m_out_of_range),
        .out_ready      (m_ready)
    );

    `TGII_ASSERT_IMPLY(a_oor_zero, m_valid && m_out_of_range, m_grid_index == '0, "out of range word with nonzero index")
    `TGII_ASSERT_IMPLY(a_stall_only_full, !s_ready, m_valid && !m_ready, "input stalled while pipeline can move")
    `TGII_ASSERT_AFTER_RESET(a_reset_empty, !m_valid, "result valid right after reset")

endmodule

/* design/tgii_cfg_regs.sv */
// configuration register file of the grid index core
// depends on tgii_pkg
module tgii_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tgii_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tgii_pkg::COORD_W-1:0]   cfg_wdata,
    output tgii_pkg::tgii_cfg_t           cfg
);
    import tgii_pkg::*;

    tgii_cfg_t cfg_reg;
    tgii_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_RANGE_LOW:   cfg_next.range_low   = cfg_wdata;
                CFG_RANGE_HIGH:  cfg_next.range_high  = cfg_wdata;
                CFG_CENTRE:      cfg_next.centre      = cfg_wdata;
                CFG_WIDTH:       cfg_next.width       = cfg_wdata;
                CFG_ANGLE_START: cfg_next.angle_start = cfg_wdata;
                CFG_INDEX_SCALE: cfg_next.index_scale = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_low   <= RST_RANGE_LOW;
            cfg_reg.range_high  <= RST_RANGE_HIGH;
            cfg_reg.centre      <= RST_CENTRE;
            cfg_reg.width       <= RST_WIDTH;
            cfg_reg.angle_start <= RST_ANGLE_START;
            cfg_reg.index_scale <= RST_INDEX_SCALE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/tgii_front.sv */
// input stage: range check, offset from centre and sign fold of the vector
// depends on tgii_pkg
module tgii_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tgii_pkg::COORD_W-1:0] coord,
    input  tgii_pkg::tgii_cfg_t         cfg,
    output logic                        out_valid,
    output tgii_pkg::cordic_word_t      out_word,
    input  logic                        out_ready
);
    import tgii_pkg::*;

    logic          vld_reg;
    cordic_word_t  word_reg;
    cordic_word_t  word_next;
    logic [CW-1:0] coord_x;
    logic [CW-1:0] centre_x;
    logic [CW-1:0] width_x;
    logic          out_low;
    logic          out_high;

    assign coord_x  = {{(CW-COORD_W){coord[COORD_W-1]}}, coord};
    assign centre_x = {{(CW-COORD_W){cfg.centre[COORD_W-1]}}, cfg.centre};
    assign width_x  = {{(CW-COORD_W){cfg.width[COORD_W-1]}}, cfg.width};

    assign out_low  = $signed(coord) < $signed(cfg.range_low);
    assign out_high = $signed(coord) > $signed(cfg.range_high);

    // negative width flips both components
    always_comb begin
        word_next.oor = out_low || out_high;
        word_next.z   = '0;
        if (cfg.width[COORD_W-1]) begin
            word_next.x = CW'(0) - width_x;
            word_next.y = centre_x - coord_x;
        end else begin
            word_next.x = width_x;
            word_next.y = coord_x - centre_x;
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

/* design/tgii_cordic.sv */
// pipelined cordic vectoring, one micro-rotation per register stage
// depends on tgii_pkg
module tgii_cordic (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tgii_pkg::cordic_word_t in_word,
    output logic                   out_valid,
    output tgii_pkg::cordic_word_t out_word,
    input  logic                   out_ready
);
    import tgii_pkg::*;

    logic [CORDIC_STAGES-1:0] vld_reg;
    cordic_word_t             word_reg [CORDIC_STAGES];
    cordic_word_t             stg_in   [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0]   vin;
    logic [CORDIC_STAGES:0]   rdy;

    assign stg_in[0]          = in_word;
    assign vin[0]             = in_valid;
    assign rdy[CORDIC_STAGES] = out_ready;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic [CW-1:0] xs;
        logic [CW-1:0] ys;
        logic          y_pos;
        cordic_word_t  word_next;

        assign xs    = CW'($signed(stg_in[i].x) >>> i);
        assign ys    = CW'($signed(stg_in[i].y) >>> i);
        assign y_pos = !stg_in[i].y[CW-1];

        always_comb begin
            word_next.oor = stg_in[i].oor;
            if (y_pos) begin
                word_next.x = stg_in[i].x + ys;
                word_next.y = stg_in[i].y - xs;
                word_next.z = stg_in[i].z + atan_entry(i);
            end else begin
                word_next.x = stg_in[i].x - ys;
                word_next.y = stg_in[i].y + xs;
                word_next.z = stg_in[i].z - atan_entry(i);
            end
        end

        assign rdy[i]        = !vld_reg[i] || rdy[i+1];
        assign vin[i+1]      = vld_reg[i];
        assign stg_in[i+1]   = word_reg[i];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                vld_reg[i] <= vin[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i] && vin[i]) begin
                word_reg[i] <= word_next;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vin[CORDIC_STAGES];
    assign out_word  = stg_in[CORDIC_STAGES];

endmodule

/* design/tgii_back.sv */
// angle offset, scaling multiply, rounding and saturation, output register
// depends on tgii_pkg
module tgii_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tgii_pkg::cordic_word_t       in_word,
    input  tgii_pkg::tgii_cfg_t          cfg,
    output logic                         out_valid,
    output logic [tgii_pkg::GRID_W-1:0]  out_grid_index,
    output logic                         out_oor,
    input  logic                         out_ready
);
    import tgii_pkg::*;

    // diff stage
    logic               d_vld_reg;
    logic [ZW-1:0]      d_diff_reg;
    logic               d_pos_reg;
    logic               d_oor_reg;
    logic [ZW:0]        diff_next;
    logic               pos_next;
    logic               d_rdy;

    // product stage
    logic               p_vld_reg;
    logic [PROD_W-1:0]  p_prod_reg;
    logic               p_pos_reg;
    logic               p_oor_reg;
    logic               p_rdy;

    // output stage
    logic               o_vld_reg;
    logic [GRID_W-1:0]  o_grid_reg;
    logic               o_oor_reg;
    logic [GRID_W-1:0]  grid_next;
    logic [PROD_W:0]    rnd_sum;
    logic [RND_W-1:0]   rnd;
    logic [PROD_W-1:0]  rnd_x;
    logic [PROD_W-1:0]  sat;
    logic               o_rdy;

    assign o_rdy = !o_vld_reg || out_ready;
    assign p_rdy = !p_vld_reg || o_rdy;
    assign d_rdy = !d_vld_reg || p_rdy;
    assign in_ready = d_rdy;

    assign diff_next = {in_word.z[ZW-1], in_word.z}
                     - {cfg.angle_start[COORD_W-1], cfg.angle_start};
    assign pos_next  = !diff_next[ZW] && (diff_next != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end else begin
            if (d_rdy) begin
                d_vld_reg <= in_valid;
            end
            if (p_rdy) begin
                p_vld_reg <= d_vld_reg;
            end
            if (o_rdy) begin
                o_vld_reg <= p_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (d_rdy && in_valid) begin
            d_diff_reg <= diff_next[ZW-1:0];
            d_pos_reg  <= pos_next;
            d_oor_reg  <= in_word.oor;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_rdy && d_vld_reg) begin
            p_prod_reg <= PROD_W'(d_diff_reg) * PROD_W'(cfg.index_scale);
            p_pos_reg  <= d_pos_reg;
            p_oor_reg  <= d_oor_reg;
        end
    end

    assign rnd_sum = {1'b0, p_prod_reg} + RND_HALF;
    assign rnd     = rnd_sum[PROD_W:RND_SHIFT];
    assign rnd_x   = PROD_W'(rnd);
    assign sat     = (rnd_x > MAX_IDX) ? MAX_IDX : rnd_x;

    always_comb begin
        if (p_oor_reg || !p_pos_reg) begin
            grid_next = '0;
        end else begin
            grid_next = sat[GRID_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (o_rdy && p_vld_reg) begin
            o_grid_reg <= grid_next;
            o_oor_reg  <= p_oor_reg;
        end
    end

    assign out_valid      = o_vld_reg;
    assign out_grid_index = o_grid_reg;
    assign out_oor        = o_oor_reg;

endmodule
